### hw/rtl/mcpi_pkg.sv
// Package for the container packet indexer: tags, sizes, phase and result codes,
// and the event and result records passed between the front and back parts.
// No dependencies.
package mcpi_pkg;

  localparam int EVQ_DEPTH = 4;
  localparam int EVQ_AW    = $clog2(EVQ_DEPTH);
  localparam int RQ_DEPTH  = 4;
  localparam int RQ_AW     = $clog2(RQ_DEPTH);

  localparam int CAP_DEPTH = 12;
  localparam int CAP_AW    = $clog2(CAP_DEPTH + 1);

  localparam logic [31:0] SIGNATURE_TAG   = 32'h2E52_4D46;
  localparam logic [31:0] TAG_PROP        = 32'h5052_4F50;
  localparam logic [31:0] TAG_DATA        = 32'h4441_5441;
  localparam logic [31:0] FIRST_CHUNK_POS = 32'h12;
  localparam logic [31:0] SIGNATURE_SIZE  = 32'd4;
  localparam logic [31:0] FIRST_SKIP      = FIRST_CHUNK_POS - SIGNATURE_SIZE;
  localparam logic [31:0] PREAMBLE_LEN    = 32'd8;
  localparam logic [15:0] PKT_HDR_SIZE    = 16'd12;

  localparam logic [CAP_AW-1:0] SIG_LAST  = CAP_AW'(4 - 1);
  localparam logic [CAP_AW-1:0] PRE_LAST  = CAP_AW'(8 - 1);
  localparam logic [CAP_AW-1:0] DHDR_LAST = CAP_AW'(10 - 1);
  localparam logic [CAP_AW-1:0] PHDR_LAST = CAP_AW'(12 - 1);

  localparam int KEY_BIT = 1;

  localparam int PTS_W = 39;
  localparam logic [6:0] PTS_SCALE = 7'd90;

  localparam int POFF_W = 6;
  localparam logic [POFF_W-1:0] POFF_TOTAL    = 6'd18;
  localparam logic [POFF_W-1:0] POFF_DURATION = 6'd22;
  localparam logic [POFF_W-1:0] POFF_DUR_END  = 6'd26;
  localparam logic [POFF_W-1:0] POFF_START    = 6'd34;
  localparam logic [POFF_W-1:0] POFF_SAT      = 6'd38;

  typedef enum logic [3:0] {
    PH_SIG,
    PH_SKIP_HDR,
    PH_PREAMBLE,
    PH_PROP,
    PH_SKIP_BODY,
    PH_DATA_HDR,
    PH_PKT_HDR,
    PH_PAYLOAD,
    PH_JUMP,
    PH_NEXT_PRE,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    K_PACKET,
    K_PROPS,
    K_FINISH,
    K_ERROR
  } kind_t;

  typedef enum logic [1:0] {
    E_NONE,
    E_SIGNATURE,
    E_LENGTH,
    E_JUMP
  } err_t;

  typedef struct packed {
    kind_t       kind;
    err_t        code;
    logic [15:0] stream;
    logic [31:0] offset;
    logic [15:0] size;
    logic [31:0] ts_ms;
    logic        key;
    logic [31:0] total;
    logic [31:0] duration;
    logic [31:0] start;
    logic        has2;
    kind_t       kind2;
    err_t        code2;
  } evt_t;

  typedef struct packed {
    kind_t            kind;
    err_t             code;
    logic [15:0]      stream;
    logic [31:0]      offset;
    logic [15:0]      size;
    logic [PTS_W-1:0] pts;
    logic             key;
    logic [31:0]      total;
    logic [31:0]      duration;
    logic [31:0]      start;
    logic             last;
  } res_t;

endpackage

### hw/rtl/media_container_packet_indexer_top.sv
// Container packet indexer, top level. Takes one file byte per cycle when not full; a byte that
// completes results passes the event queue, the staging register and the result queue in turn.
// Results leave at one per cycle while pop is high; a byte with two results is formatted twice.
// Event queue and result queue are four entries each; full rises only when the event queue fills.
// Reset (rst_n low, synchronous) returns to signature phase with signature checking enabled.
// Depends on mcpi_pkg, mcpi_front, mcpi_evq and mcpi_back.
module media_container_packet_indexer_top import mcpi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_file,
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        out_kind,
  output logic [1:0]        out_error_code,
  output logic [15:0]       out_stream_number,
  output logic [31:0]       out_payload_offset,
  output logic [15:0]       out_payload_size,
  output logic [PTS_W-1:0]  out_pts_90khz,
  output logic              out_keyframe,
  output logic [31:0]       out_total_packets,
  output logic [31:0]       out_duration_ms,
  output logic [31:0]       out_data_origin,
  output logic              out_last
);

  logic accept;
  logic ev_valid, ev_push;
  evt_t ev;
  logic evq_full, evq_valid, evq_pop;
  evt_t evq_head;
  res_t out_res;

  assign full    = evq_full;
  assign accept  = push && !full;
  assign ev_push = accept && ev_valid;

  mcpi_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .end_of_file (in_end_of_file),
    .ev_valid    (ev_valid),
    .ev          (ev)
  );

  mcpi_evq u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (ev_push),
    .wr_data   (ev),
    .rd_en     (evq_pop),
    .full      (evq_full),
    .not_empty (evq_valid),
    .head      (evq_head)
  );

  mcpi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .evq_valid (evq_valid),
    .evq_head  (evq_head),
    .evq_pop   (evq_pop),
    .pop       (pop),
    .empty     (empty),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_error_code     = out_res.code;
  assign out_stream_number  = out_res.stream;
  assign out_payload_offset = out_res.offset;
  assign out_payload_size   = out_res.size;
  assign out_pts_90khz      = out_res.pts;
  assign out_keyframe       = out_res.key;
  assign out_total_packets  = out_res.total;
  assign out_duration_ms    = out_res.duration;
  assign out_data_origin    = out_res.start;
  assign out_last           = out_res.last;

  a_second_is_terminal: assert property (@(posedge clk) disable iff (!rst_n)
    ev_push && ev.has2 |-> (ev.kind2 == K_FINISH || ev.kind2 == K_ERROR))
    else $error("second result of a byte is not a finish or error");

  a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    ev_push && (ev.has2 || ev.kind == K_FINISH || ev.kind == K_ERROR) |=> !ev_push)
    else $error("event pushed after parse finished");

  a_code_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_kind == K_ERROR) == (out_error_code != E_NONE)))
    else $error("error code inconsistent with result kind");

endmodule

### hw/rtl/mcpi_front.sv
// Front part of the packet indexer: byte-wise container parser and config register.
// Emits one event record per byte that causes results. Depends on mcpi_pkg.
module mcpi_front import mcpi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output logic       ev_valid,
  output evt_t       ev
);

  phase_t                         phase_r, phase_nxt;
  logic [31:0]                    pos_r, pos_nxt;
  logic [CAP_AW-1:0]              idx_r, idx_nxt;
  logic [CAP_DEPTH-1:0][7:0]      cap_r, cap_nxt;
  logic [31:0]                    skip_r, skip_nxt;
  logic [31:0]                    pl_r, pl_nxt;
  logic [31:0]                    noff_r, noff_nxt;
  logic [31:0]                    tot_r, tot_nxt;
  logic [31:0]                    dur_r, dur_nxt;
  logic [31:0]                    start_r, start_nxt;
  logic [POFF_W-1:0]              poff_r, poff_nxt;
  logic                           chk_r;

  logic [CAP_DEPTH-1:0][7:0]      cv;
  logic                           cap_last;
  logic                           capturing;
  logic [31:0]                    w_hi, w_size, dh_count, dh_next;
  logic [15:0]                    pk_len, pk_stream;
  logic                           pk_key;
  logic                           size_short, body_zero;
  logic [31:0]                    body;
  logic                           len_short, len_exact;
  logic [15:0]                    pay;
  logic [31:0]                    skip_dec;
  logic                           skip_end;
  logic [31:0]                    pos_inc;
  logic [31:0]                    pl_cur, gap;
  logic                           eop_more, eop_fin, eop_back;
  logic [31:0]                    tot_upd, dur_upd, start_upd;
  logic                           done_now;

  always_comb begin
    for (int i = 0; i < CAP_DEPTH; i++) begin
      cv[i] = (idx_r == CAP_AW'(i)) ? data_byte : cap_r[i];
    end
  end

  always_comb begin
    capturing = 1'b1;
    case (phase_r)
      PH_SIG:                 cap_last = (idx_r == SIG_LAST);
      PH_PREAMBLE, PH_NEXT_PRE: cap_last = (idx_r == PRE_LAST);
      PH_DATA_HDR:            cap_last = (idx_r == DHDR_LAST);
      PH_PKT_HDR:             cap_last = (idx_r == PHDR_LAST);
      default: begin
        cap_last  = 1'b0;
        capturing = 1'b0;
      end
    endcase
  end

  assign w_hi      = {cv[0], cv[1], cv[2], cv[3]};
  assign w_size    = {cv[4], cv[5], cv[6], cv[7]};
  assign dh_count  = {cv[2], cv[3], cv[4], cv[5]};
  assign dh_next   = {cv[6], cv[7], cv[8], cv[9]};
  assign pk_len    = {cv[2], cv[3]};
  assign pk_stream = {cv[4], cv[5]};
  assign pk_key    = cv[11][KEY_BIT];

  assign size_short = (w_size < PREAMBLE_LEN);
  assign body_zero  = (w_size == PREAMBLE_LEN);
  assign body       = w_size - PREAMBLE_LEN;
  assign len_short  = (pk_len < PKT_HDR_SIZE);
  assign len_exact  = (pk_len == PKT_HDR_SIZE);
  assign pay        = pk_len - PKT_HDR_SIZE;

  assign skip_dec = skip_r - 32'd1;
  assign skip_end = (skip_r == 32'd1);
  assign pos_inc  = pos_r + 32'd1;

  assign pl_cur   = (phase_r == PH_PKT_HDR) ? (pl_r - 32'd1) : pl_r;
  assign eop_more = (pl_cur != 32'd0);
  assign eop_fin  = (noff_r == 32'd0);
  assign eop_back = (noff_r < pos_inc);
  assign gap      = noff_r - pos_inc;

  assign tot_upd   = (poff_r >= POFF_TOTAL && poff_r < POFF_DURATION) ?
                     {tot_r[23:0], data_byte} : tot_r;
  assign dur_upd   = (poff_r >= POFF_DURATION && poff_r < POFF_DUR_END) ?
                     {dur_r[23:0], data_byte} : dur_r;
  assign start_upd = (poff_r >= POFF_START && poff_r < POFF_SAT) ?
                     {start_r[23:0], data_byte} : start_r;

  // event outputs
  always_comb begin
    ev       = '0;
    ev_valid = 1'b0;
    done_now = 1'b0;
    case (phase_r)
      PH_SIG: begin
        if (cap_last && chk_r && (w_hi != SIGNATURE_TAG)) begin
          ev_valid = 1'b1;
          ev.kind  = K_ERROR;
          ev.code  = E_SIGNATURE;
          done_now = 1'b1;
        end
      end
      PH_PREAMBLE: begin
        if (cap_last) begin
          if (size_short) begin
            ev_valid = 1'b1;
            ev.kind  = K_ERROR;
            ev.code  = E_LENGTH;
            done_now = 1'b1;
          end else if ((w_hi == TAG_PROP) && body_zero) begin
            ev_valid = 1'b1;
            ev.kind  = K_PROPS;
          end
        end
      end
      PH_PROP: begin
        if (skip_end) begin
          ev_valid    = 1'b1;
          ev.kind     = K_PROPS;
          ev.total    = tot_upd;
          ev.duration = dur_upd;
          ev.start    = start_upd;
        end
      end
      PH_DATA_HDR: begin
        if (cap_last && (dh_count == 32'd0)) begin
          ev_valid = 1'b1;
          ev.kind  = K_FINISH;
          done_now = 1'b1;
        end
      end
      PH_PKT_HDR: begin
        if (cap_last) begin
          ev_valid = 1'b1;
          if (len_short) begin
            ev.kind  = K_ERROR;
            ev.code  = E_LENGTH;
            done_now = 1'b1;
          end else begin
            ev.kind   = K_PACKET;
            ev.stream = pk_stream;
            ev.offset = pos_inc;
            ev.size   = pay;
            ev.ts_ms  = dh_next;
            ev.key    = pk_key;
            if (len_exact && !eop_more) begin
              if (eop_fin) begin
                ev.has2  = 1'b1;
                ev.kind2 = K_FINISH;
                done_now = 1'b1;
              end else if (eop_back) begin
                ev.has2  = 1'b1;
                ev.kind2 = K_ERROR;
                ev.code2 = E_JUMP;
                done_now = 1'b1;
              end
            end
          end
        end
      end
      PH_PAYLOAD: begin
        if (skip_end && !eop_more) begin
          if (eop_fin) begin
            ev_valid = 1'b1;
            ev.kind  = K_FINISH;
            done_now = 1'b1;
          end else if (eop_back) begin
            ev_valid = 1'b1;
            ev.kind  = K_ERROR;
            ev.code  = E_JUMP;
            done_now = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (end_of_file && !done_now && (phase_r != PH_DONE)) begin
      if (!ev_valid) begin
        ev_valid = 1'b1;
        ev.kind  = K_FINISH;
      end else begin
        ev.has2  = 1'b1;
        ev.kind2 = K_FINISH;
      end
      done_now = 1'b1;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_inc;
    idx_nxt   = idx_r;
    cap_nxt   = cap_r;
    skip_nxt  = skip_r;
    pl_nxt    = pl_r;
    noff_nxt  = noff_r;
    tot_nxt   = tot_r;
    dur_nxt   = dur_r;
    start_nxt = start_r;
    poff_nxt  = poff_r;
    if (capturing) begin
      cap_nxt = cv;
      idx_nxt = cap_last ? '0 : idx_r + CAP_AW'(1);
    end
    case (phase_r)
      PH_SIG: begin
        if (cap_last) begin
          skip_nxt  = FIRST_SKIP;
          phase_nxt = PH_SKIP_HDR;
        end
      end
      PH_SKIP_HDR, PH_SKIP_BODY, PH_JUMP: begin
        skip_nxt = skip_dec;
        if (skip_end) begin
          phase_nxt = (phase_r == PH_JUMP) ? PH_NEXT_PRE : PH_PREAMBLE;
        end
      end
      PH_PREAMBLE: begin
        if (cap_last && !size_short) begin
          if (w_hi == TAG_PROP) begin
            tot_nxt   = '0;
            dur_nxt   = '0;
            start_nxt = '0;
            poff_nxt  = '0;
            if (!body_zero) begin
              skip_nxt  = body;
              phase_nxt = PH_PROP;
            end
          end else if (w_hi == TAG_DATA) begin
            phase_nxt = PH_DATA_HDR;
          end else if (!body_zero) begin
            skip_nxt  = body;
            phase_nxt = PH_SKIP_BODY;
          end
        end
      end
      PH_PROP: begin
        tot_nxt   = tot_upd;
        dur_nxt   = dur_upd;
        start_nxt = start_upd;
        if (poff_r != POFF_SAT) begin
          poff_nxt = poff_r + POFF_W'(1);
        end
        skip_nxt = skip_dec;
        if (skip_end) begin
          phase_nxt = PH_PREAMBLE;
        end
      end
      PH_NEXT_PRE: begin
        if (cap_last) begin
          phase_nxt = PH_DATA_HDR;
        end
      end
      PH_DATA_HDR: begin
        if (cap_last) begin
          pl_nxt    = dh_count;
          noff_nxt  = dh_next;
          phase_nxt = PH_PKT_HDR;
        end
      end
      PH_PKT_HDR: begin
        if (cap_last && !len_short) begin
          pl_nxt = pl_cur;
          if (!len_exact) begin
            skip_nxt  = {16'd0, pay};
            phase_nxt = PH_PAYLOAD;
          end else if (eop_more) begin
            phase_nxt = PH_PKT_HDR;
          end else if (!eop_fin && !eop_back) begin
            skip_nxt  = gap;
            idx_nxt   = '0;
            phase_nxt = (gap != 32'd0) ? PH_JUMP : PH_NEXT_PRE;
          end
        end
      end
      PH_PAYLOAD: begin
        skip_nxt = skip_dec;
        if (skip_end) begin
          if (eop_more) begin
            phase_nxt = PH_PKT_HDR;
          end else if (!eop_fin && !eop_back) begin
            skip_nxt  = gap;
            idx_nxt   = '0;
            phase_nxt = (gap != 32'd0) ? PH_JUMP : PH_NEXT_PRE;
          end
        end
      end
      default: ;
    endcase
    if (done_now) begin
      phase_nxt = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG;
      pos_r   <= '0;
      idx_r   <= '0;
      chk_r   <= 1'b1;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        pos_r   <= pos_nxt;
        idx_r   <= idx_nxt;
      end
      if (cfg_we) begin
        chk_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cap_r   <= cap_nxt;
      skip_r  <= skip_nxt;
      pl_r    <= pl_nxt;
      noff_r  <= noff_nxt;
      tot_r   <= tot_nxt;
      dur_r   <= dur_nxt;
      start_r <= start_nxt;
      poff_r  <= poff_nxt;
    end
  end

endmodule

### hw/rtl/mcpi_evq.sv
// Event queue between the parser and the result formatter of the packet indexer.
// Small flip-flop FIFO of event records. Depends on mcpi_pkg.
module mcpi_evq import mcpi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  evt_t wr_data,
  input  logic rd_en,
  output logic full,
  output logic not_empty,
  output evt_t head
);

  evt_t [EVQ_DEPTH-1:0] mem_r;
  logic [EVQ_AW:0]      cnt_r, cnt_nxt;
  logic [EVQ_AW-1:0]    wr_r, rd_r;

  assign full      = (cnt_r == (EVQ_AW + 1)'(EVQ_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + (EVQ_AW + 1)'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - (EVQ_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wr_r  <= '0;
      rd_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wr_r <= wr_r + EVQ_AW'(1);
      end
      if (rd_en) begin
        rd_r <= rd_r + EVQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_r] <= wr_data;
    end
  end

endmodule

### hw/rtl/mcpi_back.sv
// Back part of the packet indexer: expands event records into result transactions,
// scales timestamps to 90 kHz and holds results in the output queue. Depends on mcpi_pkg.
module mcpi_back import mcpi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic evq_valid,
  input  evt_t evq_head,
  output logic evq_pop,
  input  logic pop,
  output logic empty,
  output res_t out_res
);

  logic              st_valid_r;
  logic              st_sec_r;
  evt_t              st_ev_r;
  logic [PTS_W-1:0]  st_pts_r;
  logic [PTS_W-1:0]  pts_nxt;

  res_t [RQ_DEPTH-1:0] rq_r;
  logic [RQ_AW:0]      rq_cnt_r, rq_cnt_nxt;
  logic [RQ_AW-1:0]    rq_wr_r, rq_rd_r;
  logic                rq_full, rq_pop;

  logic  res_push, st_last, st_free;
  res_t  res;

  assign rq_full  = (rq_cnt_r == (RQ_AW + 1)'(RQ_DEPTH));
  assign empty    = (rq_cnt_r == '0);
  assign rq_pop   = pop && !empty;
  assign out_res  = rq_r[rq_rd_r];

  assign res_push = st_valid_r && !rq_full;
  assign st_last  = !st_ev_r.has2 || st_sec_r;
  assign st_free  = !st_valid_r || (res_push && st_last);
  assign evq_pop  = evq_valid && st_free;
  assign pts_nxt  = PTS_W'(evq_head.ts_ms) * PTS_W'(PTS_SCALE);

  always_comb begin
    res = '0;
    if (!st_sec_r) begin
      res.kind     = st_ev_r.kind;
      res.code     = st_ev_r.code;
      res.stream   = st_ev_r.stream;
      res.offset   = st_ev_r.offset;
      res.size     = st_ev_r.size;
      res.pts      = st_pts_r;
      res.key      = st_ev_r.key;
      res.total    = st_ev_r.total;
      res.duration = st_ev_r.duration;
      res.start    = st_ev_r.start;
      res.last     = !st_ev_r.has2;
    end else begin
      res.kind = st_ev_r.kind2;
      res.code = st_ev_r.code2;
      res.last = 1'b1;
    end
  end

  always_comb begin
    rq_cnt_nxt = rq_cnt_r;
    if (res_push && !rq_pop) begin
      rq_cnt_nxt = rq_cnt_r + (RQ_AW + 1)'(1);
    end else if (rq_pop && !res_push) begin
      rq_cnt_nxt = rq_cnt_r - (RQ_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
      st_sec_r   <= 1'b0;
      rq_cnt_r   <= '0;
      rq_wr_r    <= '0;
      rq_rd_r    <= '0;
    end else begin
      if (evq_pop) begin
        st_valid_r <= 1'b1;
        st_sec_r   <= 1'b0;
      end else if (res_push && st_last) begin
        st_valid_r <= 1'b0;
      end else if (res_push) begin
        st_sec_r <= 1'b1;
      end
      rq_cnt_r <= rq_cnt_nxt;
      if (res_push) begin
        rq_wr_r <= rq_wr_r + RQ_AW'(1);
      end
      if (rq_pop) begin
        rq_rd_r <= rq_rd_r + RQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evq_pop) begin
      st_ev_r  <= evq_head;
      st_pts_r <= pts_nxt;
    end
    if (res_push) begin
      rq_r[rq_wr_r] <= res;
    end
  end

endmodule

### tb/media_container_packet_indexer_top_tb.sv
// Testbench for media_container_packet_indexer_top: builds one random container file,
// streams it through the byte queue and checks every record against a predictor.
// Depends on mcpi_pkg and the RTL of the indexer.
`timescale 1ns / 100ps

module media_container_packet_indexer_top_tb;
  import mcpi_pkg::*;

  localparam logic [31:0] TAG_CONT    = 32'h434F_4E54;
  localparam logic [31:0] TAG_MDPR    = 32'h4D44_5052;
  localparam int          FILE_TARGET = 1300;

  typedef enum int {
    END_NEXT_ZERO,
    END_ZERO_COUNT,
    END_EOF_MID,
    END_EOF_HDR,
    END_BACK_JUMP,
    END_SHORT_PKT,
    END_SHORT_CHUNK,
    END_BAD_SIG
  } ending_t;

  class index_scoreboard;
    bit          sig_check;
    phase_t      ph;
    logic [31:0] pos;
    logic [7:0]  cap [12];
    int          cap_idx;
    logic [31:0] chunk_id;
    logic [31:0] remain;
    logic [31:0] pkts_left;
    logic [31:0] next_off;
    logic [31:0] props [3];
    logic [31:0] prop_off;
    bit          halted;
    res_t        pending_records [$];
    res_t        batch [$];
    int          errors;
    int          checked;
    int          packets;
    int          prop_records;
    kind_t       last_kind;

    function new();
      sig_check = 1'b1;
      ph        = PH_SIG;
      pos       = '0;
      foreach (cap[i]) cap[i] = '0;
      cap_idx   = 0;
      chunk_id  = '0;
      remain    = '0;
      pkts_left = '0;
      next_off  = '0;
      foreach (props[i]) props[i] = '0;
      prop_off  = '0;
      halted    = 1'b0;
      errors    = 0;
      checked   = 0;
      packets   = 0;
      prop_records = 0;
      last_kind = K_PACKET;
    endfunction

    function void set_check(bit v);
      sig_check = v;
    endfunction

    function logic [15:0] be16(int i);
      return {cap[i], cap[i+1]};
    endfunction

    function logic [31:0] be32(int i);
      return {cap[i], cap[i+1], cap[i+2], cap[i+3]};
    endfunction

    function bit grab(logic [7:0] b, int need);
      if (cap_idx < 12) cap[cap_idx] = b;
      cap_idx++;
      if (cap_idx >= need) begin
        cap_idx = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void stop_with(kind_t k, err_t c);
      res_t r;
      r = '0;
      r.kind = k;
      r.code = c;
      batch.push_back(r);
      halted = 1'b1;
    endfunction

    function void add_props();
      res_t r;
      r = '0;
      r.kind     = K_PROPS;
      r.total    = props[0];
      r.duration = props[1];
      r.start    = props[2];
      batch.push_back(r);
    endfunction

    function void packet_done();
      logic [31:0] base;
      base = pos + 32'd1;
      if (pkts_left != 0) begin
        ph = PH_PKT_HDR;
      end else if (next_off == 0) begin
        stop_with(K_FINISH, E_NONE);
      end else if (next_off < base) begin
        stop_with(K_ERROR, E_JUMP);
      end else begin
        remain  = next_off - base;
        cap_idx = 0;
        ph      = (remain != 0) ? PH_JUMP : PH_NEXT_PRE;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      logic [31:0] sz;
      logic [15:0] len;
      logic [63:0] t;
      res_t        r;
      batch.delete();
      if (halted) return;
      case (ph)
        PH_SIG: begin
          if (grab(b, 4)) begin
            if (sig_check && be32(0) != SIGNATURE_TAG) begin
              stop_with(K_ERROR, E_SIGNATURE);
            end else begin
              remain = FIRST_SKIP;
              ph     = PH_SKIP_HDR;
            end
          end
        end
        PH_SKIP_HDR, PH_SKIP_BODY, PH_JUMP: begin
          remain--;
          if (remain == 0) ph = (ph == PH_JUMP) ? PH_NEXT_PRE : PH_PREAMBLE;
        end
        PH_PREAMBLE: begin
          if (grab(b, 8)) begin
            chunk_id = be32(0);
            sz       = be32(4);
            if (sz < PREAMBLE_LEN) begin
              stop_with(K_ERROR, E_LENGTH);
            end else begin
              sz = sz - PREAMBLE_LEN;
              if (chunk_id == TAG_PROP) begin
                foreach (props[i]) props[i] = '0;
                prop_off = '0;
                if (sz == 0) begin
                  add_props();
                end else begin
                  remain = sz;
                  ph     = PH_PROP;
                end
              end else if (chunk_id == TAG_DATA) begin
                ph = PH_DATA_HDR;
              end else if (sz != 0) begin
                remain = sz;
                ph     = PH_SKIP_BODY;
              end
            end
          end
        end
        PH_PROP: begin
          if (prop_off >= 18 && prop_off < 22) props[0] = {props[0][23:0], b};
          else if (prop_off >= 22 && prop_off < 26) props[1] = {props[1][23:0], b};
          else if (prop_off >= 34 && prop_off < 38) props[2] = {props[2][23:0], b};
          prop_off++;
          remain--;
          if (remain == 0) begin
            add_props();
            ph = PH_PREAMBLE;
          end
        end
        PH_NEXT_PRE: begin
          if (grab(b, 8)) ph = PH_DATA_HDR;
        end
        PH_DATA_HDR: begin
          if (grab(b, 10)) begin
            pkts_left = be32(2);
            next_off  = be32(6);
            if (pkts_left == 0) stop_with(K_FINISH, E_NONE);
            else ph = PH_PKT_HDR;
          end
        end
        PH_PKT_HDR: begin
          if (grab(b, 12)) begin
            len = be16(2);
            if (len < PKT_HDR_SIZE) begin
              stop_with(K_ERROR, E_LENGTH);
            end else begin
              t = be32(6) * 64'd90;
              r = '0;
              r.kind   = K_PACKET;
              r.stream = be16(4);
              r.offset = pos + 32'd1;
              r.size   = len - PKT_HDR_SIZE;
              r.pts    = t[PTS_W-1:0];
              r.key    = cap[11][KEY_BIT];
              batch.push_back(r);
              pkts_left--;
              if (len > PKT_HDR_SIZE) begin
                remain = {16'd0, len - PKT_HDR_SIZE};
                ph     = PH_PAYLOAD;
              end else begin
                packet_done();
              end
            end
          end
        end
        PH_PAYLOAD: begin
          remain--;
          if (remain == 0) packet_done();
        end
        default: halted = 1'b1;
      endcase
      pos++;
      if (eof && !halted) stop_with(K_FINISH, E_NONE);
      if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) pending_records.push_back(batch[i]);
    endfunction

    function void flag(string what);
      if (errors < 10) $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got)
        flag($sformatf("record %0d %s expected %0h got %0h", checked, name, want, got));
    endfunction

    function void check_record(res_t got);
      res_t e;
      if (pending_records.size() == 0) begin
        flag($sformatf("unexpected record kind %0d", got.kind));
        return;
      end
      e = pending_records.pop_front();
      cmp_field("kind", e.kind, got.kind);
      cmp_field("error_code", e.code, got.code);
      cmp_field("stream_number", e.stream, got.stream);
      cmp_field("payload_offset", e.offset, got.offset);
      cmp_field("payload_size", e.size, got.size);
      cmp_field("pts_90khz", e.pts, got.pts);
      cmp_field("keyframe", e.key, got.key);
      cmp_field("total_packets", e.total, got.total);
      cmp_field("duration_ms", e.duration, got.duration);
      cmp_field("data_origin", e.start, got.start);
      cmp_field("last", e.last, got.last);
      if (e.kind == K_PACKET) packets++;
      if (e.kind == K_PROPS) prop_records++;
      last_kind = e.kind;
      checked++;
    endfunction

    function void close();
      if (pending_records.size() != 0)
        flag($sformatf("%0d expected records never arrived", pending_records.size()));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_wdata;
  logic             push;
  logic             full;
  logic [7:0]       in_data_byte;
  logic             in_end_of_file;
  logic             empty;
  logic             pop;
  logic [1:0]       out_kind;
  logic [1:0]       out_error_code;
  logic [15:0]      out_stream_number;
  logic [31:0]      out_payload_offset;
  logic [15:0]      out_payload_size;
  logic [PTS_W-1:0] out_pts_90khz;
  logic             out_keyframe;
  logic [31:0]      out_total_packets;
  logic [31:0]      out_duration_ms;
  logic [31:0]      out_data_origin;
  logic             out_last;

  index_scoreboard sb = new();
  logic [7:0]      file_bytes [$];
  bit              check_final;
  ending_t         ending;

  media_container_packet_indexer_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .push               (push),
    .full               (full),
    .in_data_byte       (in_data_byte),
    .in_end_of_file     (in_end_of_file),
    .empty              (empty),
    .pop                (pop),
    .out_kind           (out_kind),
    .out_error_code     (out_error_code),
    .out_stream_number  (out_stream_number),
    .out_payload_offset (out_payload_offset),
    .out_payload_size   (out_payload_size),
    .out_pts_90khz      (out_pts_90khz),
    .out_keyframe       (out_keyframe),
    .out_total_packets  (out_total_packets),
    .out_duration_ms    (out_duration_ms),
    .out_data_origin    (out_data_origin),
    .out_last           (out_last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && push && !full) sb.note_byte(in_data_byte, in_end_of_file);
  end

  always @(posedge clk) begin
    res_t got;
    if (rst_n && pop && !empty) begin
      got.kind     = kind_t'(out_kind);
      got.code     = err_t'(out_error_code);
      got.stream   = out_stream_number;
      got.offset   = out_payload_offset;
      got.size     = out_payload_size;
      got.pts      = out_pts_90khz;
      got.key      = out_keyframe;
      got.total    = out_total_packets;
      got.duration = out_duration_ms;
      got.start    = out_data_origin;
      got.last     = out_last;
      sb.check_record(got);
    end
  end

  function automatic void put_bytes(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void patch32(int at, logic [31:0] v);
    for (int i = 0; i < 4; i++) file_bytes[at+i] = v[8*(3-i) +: 8];
  endfunction

  task automatic build_file();
    int          body;
    int          count;
    int          pl;
    int          gap;
    int          at;
    int          r;
    logic [31:0] tag;
    bit          first;
    bit          last_chunk;
    bit          last_pkt;
    bit          stop;
    file_bytes.delete();
    stop = 1'b0;
    if ($urandom_range(0, 99) < 3) ending = END_BAD_SIG;
    else if ($urandom_range(0, 99) < 3) ending = END_SHORT_CHUNK;
    else ending = ending_t'($urandom_range(int'(END_NEXT_ZERO), int'(END_SHORT_PKT)));
    if (ending == END_BAD_SIG && !check_final) ending = END_NEXT_ZERO;

    if (ending == END_BAD_SIG) begin
      put_bytes(SIGNATURE_TAG ^ (32'h1 << $urandom_range(0, 31)), 4);
      stop = 1'b1;
    end else if (check_final || $urandom_range(0, 1)) begin
      put_bytes(SIGNATURE_TAG, 4);
    end else begin
      put_bytes($urandom, 4);
    end
    put_bytes(32'h00, 1);
    put_bytes(32'hFF, 1);
    repeat (12) put_bytes($urandom, 1);

    if (!stop) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 3))
          0: tag = TAG_PROP;
          1: tag = TAG_CONT;
          2: tag = TAG_MDPR;
          default: begin
            tag = $urandom;
            if (tag == TAG_PROP || tag == TAG_DATA) tag ^= 32'h1;
          end
        endcase
        if (tag == TAG_PROP) begin
          case ($urandom_range(0, 3))
            0: body = 0;
            1: body = $urandom_range(1, 37);
            2: body = 50;
            default: body = $urandom_range(38, 64);
          endcase
        end else begin
          body = $urandom_range(0, 1) ? 0 : $urandom_range(1, 30);
        end
        put_bytes(tag, 4);
        put_bytes(body + 8, 4);
        repeat (body) put_bytes($urandom, 1);
      end
      if (ending == END_SHORT_CHUNK) begin
        put_bytes($urandom, 4);
        put_bytes($urandom_range(0, 7), 4);
        stop = 1'b1;
      end
    end

    if (!stop) begin
      put_bytes(TAG_DATA, 4);
      put_bytes($urandom | 32'h8, 4);
    end
    first = 1'b1;
    while (!stop) begin
      if (!first) repeat (8) put_bytes($urandom, 1);
      first = 1'b0;
      at = file_bytes.size();
      put_bytes($urandom, 2);
      put_bytes(32'h0, 4);
      put_bytes(32'h0, 4);
      last_chunk = file_bytes.size() >= FILE_TARGET;
      count = $urandom_range(1, 6);
      if (last_chunk && ending == END_ZERO_COUNT) begin
        count = 0;
        stop  = 1'b1;
      end
      patch32(at + 2, count);
      for (int p = 0; p < count && !stop; p++) begin
        last_pkt = last_chunk && (p == count - 1);
        r  = $urandom_range(0, 99);
        pl = (r < 35) ? 0 : (r < 90) ? $urandom_range(1, 16) : $urandom_range(17, 200);
        if (last_pkt && ending == END_EOF_MID && pl < 2) pl = 2;
        put_bytes($urandom, 2);
        if (last_pkt && ending == END_SHORT_PKT) put_bytes($urandom_range(0, 11), 2);
        else put_bytes(pl + 12, 2);
        case ($urandom_range(0, 7))
          0: put_bytes(32'h0000, 2);
          1: put_bytes(32'hFFFF, 2);
          default: put_bytes($urandom, 2);
        endcase
        case ($urandom_range(0, 7))
          0: put_bytes(32'h0000_0000, 4);
          1: put_bytes(32'hFFFF_FFFF, 4);
          default: put_bytes($urandom, 4);
        endcase
        put_bytes($urandom, 2);
        if (last_pkt && (ending == END_EOF_HDR || ending == END_SHORT_PKT)) begin
          stop = 1'b1;
        end else if (last_pkt && ending == END_EOF_MID) begin
          repeat ($urandom_range(1, pl - 1)) put_bytes($urandom, 1);
          stop = 1'b1;
        end else begin
          repeat (pl) put_bytes($urandom, 1);
        end
      end
      if (!stop) begin
        if (!last_chunk) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          patch32(at + 6, file_bytes.size() + gap);
          repeat (gap) put_bytes($urandom, 1);
        end else begin
          if (ending == END_BACK_JUMP)
            patch32(at + 6, $urandom_range(1, file_bytes.size() - 1));
          stop = 1'b1;
        end
      end
    end

    // trailing bytes arrive after the parse has ended and must be ignored
    if (ending != END_EOF_MID && ending != END_EOF_HDR) begin
      repeat ($urandom_range(1, 6)) put_bytes($urandom, 1);
      while (file_bytes.size() < FILE_TARGET) put_bytes($urandom, 1);
    end
  endtask

  task automatic write_check(bit v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_check(v);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_file();
    int k;
    k = 0;
    while (k < file_bytes.size()) begin
      if (!(k >= 700 && k < 900) && $urandom_range(0, 99) < 35) begin
        push <= 1'b0;
        @(posedge clk);
      end else begin
        push           <= 1'b1;
        in_data_byte   <= file_bytes[k];
        in_end_of_file <= (k == file_bytes.size() - 1);
        @(posedge clk);
        if (!full) k++;
      end
    end
    push <= 1'b0;
  endtask

  initial begin : receiver
    int cyc;
    int hold;
    cyc  = 0;
    hold = 0;
    pop <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      // hold off long enough for the queues to fill and stall the sender
      if (cyc == 300) hold = 500;
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else begin
        pop <= (cyc >= 1400 && cyc < 1900) || ($urandom_range(0, 99) >= 35);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("media_container_packet_indexer_top test failed");
    $finish;
  end

  initial begin : main
    int waited;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 1'b0;
    push           <= 1'b0;
    in_data_byte   <= 8'h00;
    in_end_of_file <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_final = $urandom_range(0, 1);
    write_check(1'b1);
    write_check(1'b0);
    write_check(check_final);

    build_file();
    send_file();
    @(posedge clk);

    waited = 0;
    while (sb.pending_records.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    write_check(!check_final);
    repeat (4) @(posedge clk);
    sb.close();

    $display("Streamed %0d file bytes with signature check %0d, ending case %s.",
             file_bytes.size(), check_final, ending.name());
    $display("Checked %0d records: %0d packets, %0d property records, final kind %s.",
             sb.checked, sb.packets, sb.prop_records, sb.last_kind.name());
    if (sb.errors == 0) begin
      $display("media_container_packet_indexer_top test passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("media_container_packet_indexer_top test failed");
    end
    $finish;
  end

endmodule
